### design/rbst_pkg.sv
// Shared types, constants and register codes of the rigid body sleep tracker.
package rbst_pkg;

  localparam int BODY_INDEX_W = 10;
  localparam int BODY_COUNT   = 1 << BODY_INDEX_W;

  localparam int VEL_W    = 16;
  localparam int POS_W    = 32;
  localparam int STEP_W   = 16;
  localparam int TIMER_W  = 32;
  localparam int RADIUS_W = 16;
  localparam int AXES     = 3;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_FIFO_PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int OUT_FIFO_CNT_W = OUT_FIFO_PTR_W + 1;

  localparam logic [31:0] LINEAR_REST_SQ_RST  = 32'd655;
  localparam logic [31:0] ANGULAR_REST_SQ_RST = 32'd655;
  localparam logic [31:0] REST_TIME_RST       = 32'd32768;
  localparam logic [15:0] STILL_RADIUS_RST    = 16'd4;
  localparam logic [31:0] STILL_TIME_RST      = 32'd131072;

  typedef enum logic [2:0] {
    REG_LINEAR_REST_SQ  = 3'd0,
    REG_ANGULAR_REST_SQ = 3'd1,
    REG_REST_TIME       = 3'd2,
    REG_STILL_RADIUS    = 3'd3,
    REG_STILL_TIME      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [TIMER_W-1:0] linear_rest_sq;
    logic [TIMER_W-1:0] angular_rest_sq;
    logic [TIMER_W-1:0] rest_time;
    logic [TIMER_W-1:0] still_radius_sq;
    logic [TIMER_W-1:0] still_time;
  } cfg_t;

  typedef struct packed {
    logic [BODY_INDEX_W-1:0]        body_index;
    logic                           is_static;
    logic [AXES-1:0][VEL_W-1:0]     lin_vel;
    logic [AXES-1:0][VEL_W-1:0]     ang_vel;
    logic [AXES-1:0][POS_W-1:0]     pos;
    logic [STEP_W-1:0]              step_time;
  } in_item_t;

  typedef struct packed {
    logic                       sleeping;
    logic [TIMER_W-1:0]         slow_timer;
    logic [TIMER_W-1:0]         still_timer;
    logic [AXES-1:0][POS_W-1:0] ref_pos;
  } state_t;

  typedef struct packed {
    logic [BODY_INDEX_W-1:0] body_index;
    logic                    asleep;
    logic                    zero_velocity;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic s1_valid;
    logic s2_valid;
  } pipe_status_t;

endpackage

### design/rbst_in_if.sv
// Input channel carrying one body record per item.
interface rbst_in_if;
  logic                                valid;
  logic                                ready;
  logic [rbst_pkg::BODY_INDEX_W-1:0]   body_index;
  logic                                is_static;
  logic signed [rbst_pkg::VEL_W-1:0]   lin_vel_x;
  logic signed [rbst_pkg::VEL_W-1:0]   lin_vel_y;
  logic signed [rbst_pkg::VEL_W-1:0]   lin_vel_z;
  logic signed [rbst_pkg::VEL_W-1:0]   ang_vel_x;
  logic signed [rbst_pkg::VEL_W-1:0]   ang_vel_y;
  logic signed [rbst_pkg::VEL_W-1:0]   ang_vel_z;
  logic signed [rbst_pkg::POS_W-1:0]   pos_x;
  logic signed [rbst_pkg::POS_W-1:0]   pos_y;
  logic signed [rbst_pkg::POS_W-1:0]   pos_z;
  logic [rbst_pkg::STEP_W-1:0]         step_time;

  modport source (
    output valid, body_index, is_static, lin_vel_x, lin_vel_y, lin_vel_z,
           ang_vel_x, ang_vel_y, ang_vel_z, pos_x, pos_y, pos_z, step_time,
    input  ready
  );

  modport sink (
    input  valid, body_index, is_static, lin_vel_x, lin_vel_y, lin_vel_z,
           ang_vel_x, ang_vel_y, ang_vel_z, pos_x, pos_y, pos_z, step_time,
    output ready
  );
endinterface

### design/rbst_out_if.sv
// Result channel carrying the sleep state of one body per item.
interface rbst_out_if;
  logic                              valid;
  logic                              ready;
  logic [rbst_pkg::BODY_INDEX_W-1:0] body_index_out;
  logic                              asleep;
  logic                              zero_velocity;

  modport source (
    output valid, body_index_out, asleep, zero_velocity,
    input  ready
  );

  modport sink (
    input  valid, body_index_out, asleep, zero_velocity,
    output ready
  );
endinterface

### design/rbst_state_ram.sv
// Generic simple dual-port RAM with registered read data.
module rbst_state_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/rbst_cfg.sv
// APB-style configuration registers of the sleep tracker.
module rbst_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbst_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rbst_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rbst_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output rbst_pkg::cfg_t                  cfg
);

  logic [31:0] linear_rest_sq_r;
  logic [31:0] angular_rest_sq_r;
  logic [31:0] rest_time_r;
  logic [15:0] still_radius_r;
  logic [31:0] still_radius_sq_r;
  logic [31:0] still_time_r;
  logic [31:0] still_radius_sq_nxt;
  logic        wr_en;
  rbst_pkg::reg_index_t reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = rbst_pkg::reg_index_t'(paddr[4:2]);
  assign pready  = 1'b1;

  // The tolerance is compared squared, so the square is kept next to it.
  assign still_radius_sq_nxt = pwdata[15:0] * pwdata[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linear_rest_sq_r  <= rbst_pkg::LINEAR_REST_SQ_RST;
      angular_rest_sq_r <= rbst_pkg::ANGULAR_REST_SQ_RST;
      rest_time_r       <= rbst_pkg::REST_TIME_RST;
      still_radius_r    <= rbst_pkg::STILL_RADIUS_RST;
      still_radius_sq_r <= 32'(rbst_pkg::STILL_RADIUS_RST) * 32'(rbst_pkg::STILL_RADIUS_RST);
      still_time_r      <= rbst_pkg::STILL_TIME_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        rbst_pkg::REG_LINEAR_REST_SQ:  linear_rest_sq_r  <= pwdata;
        rbst_pkg::REG_ANGULAR_REST_SQ: angular_rest_sq_r <= pwdata;
        rbst_pkg::REG_REST_TIME:       rest_time_r       <= pwdata;
        rbst_pkg::REG_STILL_RADIUS: begin
          still_radius_r    <= pwdata[15:0];
          still_radius_sq_r <= still_radius_sq_nxt;
        end
        rbst_pkg::REG_STILL_TIME:      still_time_r      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      rbst_pkg::REG_LINEAR_REST_SQ:  prdata = linear_rest_sq_r;
      rbst_pkg::REG_ANGULAR_REST_SQ: prdata = angular_rest_sq_r;
      rbst_pkg::REG_REST_TIME:       prdata = rest_time_r;
      rbst_pkg::REG_STILL_RADIUS:    prdata = {16'd0, still_radius_r};
      rbst_pkg::REG_STILL_TIME:      prdata = still_time_r;
      default:                       prdata = '0;
    endcase
  end

  assign cfg.linear_rest_sq  = linear_rest_sq_r;
  assign cfg.angular_rest_sq = angular_rest_sq_r;
  assign cfg.rest_time       = rest_time_r;
  assign cfg.still_radius_sq = still_radius_sq_r;
  assign cfg.still_time      = still_time_r;

endmodule

### design/rbst_out_fifo.sv
// Small result queue that decouples the pipeline from the result channel.
module rbst_out_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  rbst_pkg::res_t                      push_data,
  input  logic                                pop,
  output logic                                out_valid,
  output rbst_pkg::res_t                      out_data,
  output logic [rbst_pkg::OUT_FIFO_CNT_W-1:0] count
);

  rbst_pkg::res_t                      mem [rbst_pkg::OUT_FIFO_DEPTH];
  logic [rbst_pkg::OUT_FIFO_PTR_W-1:0] wr_ptr_r;
  logic [rbst_pkg::OUT_FIFO_PTR_W-1:0] rd_ptr_r;
  logic [rbst_pkg::OUT_FIFO_CNT_W-1:0] cnt_r;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/rbst_track_pipe.sv
// Read-modify-write pipeline over the per-body state memory, with forwarding.
module rbst_track_pipe (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rbst_pkg::cfg_t         cfg,
  input  logic                   acc,
  input  rbst_pkg::in_item_t     item,
  output logic                   res_valid,
  output rbst_pkg::res_t         res,
  output rbst_pkg::pipe_status_t status
);

  typedef struct packed {
    logic        big;
    logic [15:0] mag;
  } gap_t;

  function automatic logic [31:0] vel_sq(input logic [15:0] v);
    logic [15:0] m;
    m = v[15] ? (~v + 16'd1) : v;
    return m * m;
  endfunction

  // Distances of 2^16 or more already exceed any tolerance squared.
  function automatic gap_t pos_gap(input logic [31:0] p, input logic [31:0] r);
    logic [32:0] d;
    logic [32:0] m;
    gap_t        g;
    d = {p[31], p} - {r[31], r};
    m = d[32] ? (~d + 33'd1) : d;
    g.big = |m[32:16];
    g.mag = m[15:0];
    return g;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Memory port
  logic                              ram_we;
  logic [rbst_pkg::BODY_INDEX_W-1:0] ram_waddr;
  rbst_pkg::state_t                  ram_wdata;
  rbst_pkg::state_t                  ram_rdata;

  // Clearing pass after reset
  logic                              clearing_r;
  logic [rbst_pkg::BODY_INDEX_W-1:0] clr_idx_r;

  // Stage 1: memory data arrives, velocity test, state selection
  logic               s1_v_r;
  rbst_pkg::in_item_t s1_item_r;

  // Stage 2: position test and state update
  logic                                   s2_v_r;
  logic [rbst_pkg::BODY_INDEX_W-1:0]      s2_idx_r;
  logic                                   s2_static_r;
  logic                                   s2_slow_r;
  logic [rbst_pkg::STEP_W-1:0]            s2_dt_r;
  logic [rbst_pkg::AXES-1:0][31:0]        s2_pos_r;
  rbst_pkg::state_t                       s2_st_r;
  gap_t [rbst_pkg::AXES-1:0]              s2_gap_r;

  // Last written entry, for a read that raced the write
  logic                              wb_v_r;
  logic [rbst_pkg::BODY_INDEX_W-1:0] wb_idx_r;
  rbst_pkg::state_t                  wb_st_r;

  logic                             hit_s2;
  logic                             hit_wb;
  rbst_pkg::state_t                 base_st;
  rbst_pkg::state_t                 sel_st;
  gap_t [rbst_pkg::AXES-1:0]        gap_base;
  gap_t [rbst_pkg::AXES-1:0]        gap_pos;
  gap_t [rbst_pkg::AXES-1:0]        gap_old;
  gap_t [rbst_pkg::AXES-1:0]        sel_gap;
  logic [31:0]                      lin_sum;
  logic [31:0]                      ang_sum;
  logic                             s1_slow;

  logic [31:0]      sq [rbst_pkg::AXES];
  logic [33:0]      d2;
  logic             any_big;
  logic             near;
  logic [31:0]      slow_sum;
  logic [31:0]      still_sum;
  logic             asleep;
  logic             zv;
  logic             reload;
  rbst_pkg::state_t s2_new;

  rbst_state_ram #(
    .WIDTH($bits(rbst_pkg::state_t)),
    .DEPTH(rbst_pkg::BODY_COUNT)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(item.body_index),
    .rdata(ram_rdata)
  );

  // ---------------- Stage 1 ----------------
  assign lin_sum = vel_sq(s1_item_r.lin_vel[0]) + vel_sq(s1_item_r.lin_vel[1]) +
                   vel_sq(s1_item_r.lin_vel[2]);
  assign ang_sum = vel_sq(s1_item_r.ang_vel[0]) + vel_sq(s1_item_r.ang_vel[1]) +
                   vel_sq(s1_item_r.ang_vel[2]);
  assign s1_slow = (lin_sum < cfg.linear_rest_sq) && (ang_sum < cfg.angular_rest_sq);

  assign hit_s2  = s2_v_r && (s2_idx_r == s1_item_r.body_index);
  assign hit_wb  = wb_v_r && (wb_idx_r == s1_item_r.body_index);
  assign base_st = hit_wb ? wb_st_r : ram_rdata;
  assign sel_st  = hit_s2 ? s2_new : base_st;

  // The reference of an item one stage ahead is either its old reference or
  // its own position, so both distances are formed early and picked late.
  always_comb begin
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      gap_base[a] = pos_gap(s1_item_r.pos[a], base_st.ref_pos[a]);
      gap_pos[a]  = pos_gap(s1_item_r.pos[a], s2_pos_r[a]);
      gap_old[a]  = pos_gap(s1_item_r.pos[a], s2_st_r.ref_pos[a]);
    end
    if (!hit_s2) begin
      sel_gap = gap_base;
    end else if (reload) begin
      sel_gap = gap_pos;
    end else begin
      sel_gap = gap_old;
    end
  end

  // ---------------- Stage 2 ----------------
  always_comb begin
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      sq[a] = s2_gap_r[a].mag * s2_gap_r[a].mag;
    end
  end

  assign d2        = 34'(sq[0]) + 34'(sq[1]) + 34'(sq[2]);
  assign any_big   = s2_gap_r[0].big || s2_gap_r[1].big || s2_gap_r[2].big;
  assign near      = !any_big && (d2 < {2'b00, cfg.still_radius_sq});
  assign slow_sum  = sat_add(s2_st_r.slow_timer, s2_dt_r);
  assign still_sum = sat_add(s2_st_r.still_timer, s2_dt_r);

  always_comb begin
    s2_new = s2_st_r;
    asleep = s2_st_r.sleeping;
    zv     = 1'b0;
    reload = 1'b0;
    if (!s2_static_r) begin
      if (s2_slow_r) begin
        s2_new.slow_timer = slow_sum;
        if ((slow_sum >= cfg.rest_time) && !asleep) begin
          asleep = 1'b1;
          zv     = 1'b1;
        end
      end else begin
        s2_new.slow_timer = '0;
        asleep            = 1'b0;
      end
      // A body still awake gets the position test as well.
      if (!asleep) begin
        if (near) begin
          s2_new.still_timer = still_sum;
          if (still_sum >= cfg.still_time) begin
            asleep = 1'b1;
            zv     = 1'b1;
          end
        end else begin
          s2_new.ref_pos     = s2_pos_r;
          s2_new.still_timer = '0;
          reload             = 1'b1;
        end
      end
      s2_new.sleeping = asleep;
    end
  end

  assign ram_we    = clearing_r || s2_v_r;
  assign ram_waddr = clearing_r ? clr_idx_r : s2_idx_r;
  assign ram_wdata = clearing_r ? '0 : s2_new;

  assign res_valid         = s2_v_r;
  assign res.body_index    = s2_idx_r;
  assign res.asleep        = asleep;
  assign res.zero_velocity = zv;

  assign status.clearing = clearing_r;
  assign status.s1_valid = s1_v_r;
  assign status.s2_valid = s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      wb_v_r     <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == rbst_pkg::BODY_INDEX_W'(rbst_pkg::BODY_COUNT - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      wb_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r <= item;
    end
    if (s1_v_r) begin
      s2_idx_r    <= s1_item_r.body_index;
      s2_static_r <= s1_item_r.is_static;
      s2_slow_r   <= s1_slow;
      s2_dt_r     <= s1_item_r.step_time;
      s2_pos_r    <= s1_item_r.pos;
      s2_st_r     <= sel_st;
      s2_gap_r    <= sel_gap;
    end
    if (s2_v_r) begin
      wb_idx_r <= s2_idx_r;
      wb_st_r  <= s2_new;
    end
  end

endmodule

### design/rigid_body_sleep_tracker_core.sv
// Top level of the rigid body sleep tracker: channels, registers and pipeline.
// The block takes one body record per clock cycle while it is not clearing and
// a result queue slot is free, and returns its asleep flag and zero-velocity
// pulse in input order. The per-body state sits in one 1024-entry memory that
// is read when an item is accepted and written back from stage 2; results of
// the two items ahead are forwarded, so the same body may arrive in consecutive
// cycles at full rate. A four-entry result queue keeps the input open while
// results wait on the output. After reset a clearing pass zeroes all 1024
// entries of the state memory, during which no item is accepted.
module rigid_body_sleep_tracker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  rbst_in_if.sink                         in_ch,
  rbst_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbst_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rbst_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rbst_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  rbst_pkg::cfg_t                      cfg;
  rbst_pkg::in_item_t                  item;
  rbst_pkg::res_t                      res;
  rbst_pkg::res_t                      fifo_data;
  rbst_pkg::pipe_status_t              status;
  logic                                res_valid;
  logic                                acc;
  logic                                pop;
  logic                                fifo_valid;
  logic [rbst_pkg::OUT_FIFO_CNT_W-1:0] fifo_cnt;
  logic [rbst_pkg::OUT_FIFO_CNT_W-1:0] reserved;

  rbst_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  assign item.body_index = in_ch.body_index;
  assign item.is_static  = in_ch.is_static;
  assign item.lin_vel[0] = in_ch.lin_vel_x;
  assign item.lin_vel[1] = in_ch.lin_vel_y;
  assign item.lin_vel[2] = in_ch.lin_vel_z;
  assign item.ang_vel[0] = in_ch.ang_vel_x;
  assign item.ang_vel[1] = in_ch.ang_vel_y;
  assign item.ang_vel[2] = in_ch.ang_vel_z;
  assign item.pos[0]     = in_ch.pos_x;
  assign item.pos[1]     = in_ch.pos_y;
  assign item.pos[2]     = in_ch.pos_z;
  assign item.step_time  = in_ch.step_time;

  // Every item in flight has a queue slot reserved before it is accepted.
  assign reserved = fifo_cnt + rbst_pkg::OUT_FIFO_CNT_W'(status.s1_valid) +
                    rbst_pkg::OUT_FIFO_CNT_W'(status.s2_valid);
  assign in_ch.ready = !status.clearing &&
                       (reserved < rbst_pkg::OUT_FIFO_CNT_W'(rbst_pkg::OUT_FIFO_DEPTH));
  assign acc = in_ch.valid && in_ch.ready;

  rbst_track_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .acc      (acc),
    .item     (item),
    .res_valid(res_valid),
    .res      (res),
    .status   (status)
  );

  assign pop = out_ch.valid && out_ch.ready;

  rbst_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .pop      (pop),
    .out_valid(fifo_valid),
    .out_data (fifo_data),
    .count    (fifo_cnt)
  );

  assign out_ch.valid          = fifo_valid;
  assign out_ch.body_index_out = fifo_data.body_index;
  assign out_ch.asleep         = fifo_data.asleep;
  assign out_ch.zero_velocity  = fifo_data.zero_velocity;

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (fifo_cnt < rbst_pkg::OUT_FIFO_CNT_W'(rbst_pkg::OUT_FIFO_DEPTH)))
    else $error("result pushed into a full queue");

  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##2 res_valid)
    else $error("accepted item did not reach the update stage");

  a_pulse_asleep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.zero_velocity) |-> out_ch.asleep)
    else $error("zero-velocity pulse on a body that is awake");

  a_no_item_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> (!status.s1_valid && !status.s2_valid))
    else $error("item in flight during the clearing pass");

endmodule

### sim/rigid_body_sleep_tracker_core_tb.sv
// Self-checking testbench of the rigid body sleep tracker core.
module rigid_body_sleep_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 6000;
  localparam int POOL_SIZE   = 12;
  localparam int PHASE_COUNT = 6;

  // Register settings per random phase:
  // linear_rest_sq, angular_rest_sq, rest_time, still_radius, still_time.
  localparam logic [31:0] PHASE_CFG [PHASE_COUNT][5] = '{
    '{32'd655, 32'd655, 32'd32768, 32'd4, 32'd131072},
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF},
    '{32'd400, 32'd900, 32'd200000, 32'd16, 32'd300000},
    '{32'd1200, 32'd300, 32'd65536, 32'd64, 32'd98304}
  };
  localparam int PHASE_ITEMS [PHASE_COUNT] = '{150, 80, 80, 80, 180, 180};

  typedef struct {
    rbst_pkg::in_item_t body;
    bit                 typed;
    rbst_pkg::res_t     want;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [rbst_pkg::CFG_ADDR_W-1:0] paddr;
  logic [rbst_pkg::CFG_DATA_W-1:0] pwdata;
  logic [rbst_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  rbst_in_if  in_ch ();
  rbst_out_if out_ch ();

  rigid_body_sleep_tracker_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the registers and of the per-body sleep state.
  logic [rbst_pkg::TIMER_W-1:0]  lin_rest_sq;
  logic [rbst_pkg::TIMER_W-1:0]  ang_rest_sq;
  logic [rbst_pkg::TIMER_W-1:0]  rest_dur;
  logic [rbst_pkg::RADIUS_W-1:0] still_rad;
  logic [rbst_pkg::TIMER_W-1:0]  still_dur;
  logic                          body_asleep    [rbst_pkg::BODY_COUNT];
  logic [rbst_pkg::TIMER_W-1:0]  slow_time_acc  [rbst_pkg::BODY_COUNT];
  logic [rbst_pkg::TIMER_W-1:0]  still_time_acc [rbst_pkg::BODY_COUNT];
  logic [rbst_pkg::AXES-1:0][rbst_pkg::POS_W-1:0] anchor_pos [rbst_pkg::BODY_COUNT];

  rbst_pkg::res_t due_results [$];
  probe_t         probes [$];
  rbst_pkg::res_t oldest_due;
  int             bodies_in_play [POOL_SIZE];
  bit             no_idle;
  int             sink_wait = 0;
  int             quiet_cycles = 0;
  int             fault_count = 0;
  int             cfg_fault_count;
  int             items_sent;
  int             results_checked = 0;
  int             sleeps_seen = 0;
  int             settings_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] vel_sq(input logic [rbst_pkg::VEL_W-1:0] v);
    longint s;
    s = longint'($signed(v));
    if (s < 0) s = -s;
    return 64'(s * s);
  endfunction

  // Differences are clamped to the signed 32-bit range before squaring.
  function automatic logic [63:0] offset_sq(input logic [rbst_pkg::POS_W-1:0] p,
                                            input logic [rbst_pkg::POS_W-1:0] q);
    longint d;
    d = longint'($signed(p)) - longint'($signed(q));
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    if (d < 0) d = -d;
    return 64'(d * d);
  endfunction

  function automatic logic [rbst_pkg::TIMER_W-1:0] timer_add(
      input logic [rbst_pkg::TIMER_W-1:0] acc,
      input logic [rbst_pkg::STEP_W-1:0]  dt);
    logic [rbst_pkg::TIMER_W:0] s;
    s = {1'b0, acc} + (rbst_pkg::TIMER_W + 1)'(dt);
    return s[rbst_pkg::TIMER_W] ? {rbst_pkg::TIMER_W{1'b1}} : s[rbst_pkg::TIMER_W-1:0];
  endfunction

  function automatic rbst_pkg::res_t predict_sleep(input rbst_pkg::in_item_t b);
    rbst_pkg::res_t r;
    logic [63:0]    lin_sq;
    logic [63:0]    ang_sq;
    logic [63:0]    dist_sq;
    logic           asleep;
    int unsigned    i;
    i = b.body_index;
    r.body_index = b.body_index;
    r.asleep = 1'b0;
    r.zero_velocity = 1'b0;
    if (b.is_static) begin
      r.asleep = body_asleep[i];
      return r;
    end
    asleep = body_asleep[i];
    lin_sq = '0;
    ang_sq = '0;
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      lin_sq += vel_sq(b.lin_vel[a]);
      ang_sq += vel_sq(b.ang_vel[a]);
    end
    if (lin_sq < 64'(lin_rest_sq) && ang_sq < 64'(ang_rest_sq)) begin
      slow_time_acc[i] = timer_add(slow_time_acc[i], b.step_time);
      if (slow_time_acc[i] >= rest_dur && !asleep) begin
        asleep = 1'b1;
        r.zero_velocity = 1'b1;
      end
    end else begin
      slow_time_acc[i] = '0;
      asleep = 1'b0;
    end
    // The position test only runs for a body still awake, so a body woken
    // above can fall asleep again in the same step.
    if (!asleep) begin
      dist_sq = '0;
      for (int a = 0; a < rbst_pkg::AXES; a++)
        dist_sq += offset_sq(b.pos[a], anchor_pos[i][a]);
      if (dist_sq < 64'(still_rad) * 64'(still_rad)) begin
        still_time_acc[i] = timer_add(still_time_acc[i], b.step_time);
        if (still_time_acc[i] >= still_dur) begin
          asleep = 1'b1;
          r.zero_velocity = 1'b1;
        end
      end else begin
        anchor_pos[i] = b.pos;
        still_time_acc[i] = '0;
      end
    end
    body_asleep[i] = asleep;
    r.asleep = asleep;
    return r;
  endfunction

  function automatic rbst_pkg::in_item_t make_body(input int unsigned idx, input bit stat,
                                                   input int lv, input int av, input int px,
                                                   input int py, input int pz,
                                                   input int unsigned dt);
    rbst_pkg::in_item_t b;
    b.body_index = rbst_pkg::BODY_INDEX_W'(idx);
    b.is_static = stat;
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      b.lin_vel[a] = rbst_pkg::VEL_W'(lv);
      b.ang_vel[a] = rbst_pkg::VEL_W'(av);
    end
    b.pos[0] = rbst_pkg::POS_W'(px);
    b.pos[1] = rbst_pkg::POS_W'(py);
    b.pos[2] = rbst_pkg::POS_W'(pz);
    b.step_time = rbst_pkg::STEP_W'(dt);
    return b;
  endfunction

  function automatic void add_probe(input rbst_pkg::in_item_t b, input bit typed = 1'b0,
                                    input bit sl = 1'b0, input bit zv = 1'b0);
    probe_t p;
    p.body = b;
    p.typed = typed;
    p.want.body_index = b.body_index;
    p.want.asleep = sl;
    p.want.zero_velocity = zv;
    probes.insert(probes.size(), p);
  endfunction

  function automatic logic [rbst_pkg::VEL_W-1:0] slow_component();
    return rbst_pkg::VEL_W'(int'($urandom_range(0, 40)) - 20);
  endfunction

  // Mostly well-formed motion of a few bodies: slow velocities and positions
  // that hover around the stored anchor, mixed with fast and raw items.
  function automatic rbst_pkg::in_item_t random_body();
    rbst_pkg::in_item_t b;
    int unsigned        pick;
    int unsigned        idx;
    int                 span;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      b.body_index = rbst_pkg::BODY_INDEX_W'($urandom);
      b.is_static = 1'($urandom_range(0, 1));
      for (int a = 0; a < rbst_pkg::AXES; a++) begin
        b.lin_vel[a] = rbst_pkg::VEL_W'($urandom);
        b.ang_vel[a] = rbst_pkg::VEL_W'($urandom);
        b.pos[a] = $urandom;
      end
      b.step_time = rbst_pkg::STEP_W'($urandom);
      return b;
    end
    idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, rbst_pkg::BODY_COUNT - 1)
                                       : bodies_in_play[$urandom_range(0, POOL_SIZE - 1)];
    b.body_index = rbst_pkg::BODY_INDEX_W'(idx);
    b.is_static = ($urandom_range(0, 11) == 0);
    pick = $urandom_range(0, 99);
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      if (pick < 65) begin
        b.lin_vel[a] = slow_component();
        b.ang_vel[a] = slow_component();
      end else if (pick < 85) begin
        b.lin_vel[a] = rbst_pkg::VEL_W'($urandom);
        b.ang_vel[a] = rbst_pkg::VEL_W'($urandom);
      end else begin
        b.lin_vel[a] = (a == 0) ? rbst_pkg::VEL_W'($urandom) : slow_component();
        b.ang_vel[a] = slow_component();
      end
    end
    span = int'(still_rad) / 2 + 1;
    pick = $urandom_range(0, 99);
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      if (pick < 70)
        b.pos[a] = anchor_pos[idx][a] +
                   rbst_pkg::POS_W'(int'($urandom_range(0, 2 * span)) - span);
      else if (pick < 85)
        b.pos[a] = $urandom;
      else
        b.pos[a] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50)      b.step_time = rbst_pkg::STEP_W'($urandom);
    else if (pick < 75) b.step_time = {rbst_pkg::STEP_W{1'b1}};
    else                b.step_time = rbst_pkg::STEP_W'($urandom_range(0, 100));
    return b;
  endfunction

  task automatic send_body(input rbst_pkg::in_item_t b, input bit typed,
                           input rbst_pkg::res_t want);
    int             gap;
    rbst_pkg::res_t model;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.body_index <= b.body_index;
    in_ch.is_static  <= b.is_static;
    in_ch.lin_vel_x  <= b.lin_vel[0];
    in_ch.lin_vel_y  <= b.lin_vel[1];
    in_ch.lin_vel_z  <= b.lin_vel[2];
    in_ch.ang_vel_x  <= b.ang_vel[0];
    in_ch.ang_vel_y  <= b.ang_vel[1];
    in_ch.ang_vel_z  <= b.ang_vel[2];
    in_ch.pos_x      <= b.pos[0];
    in_ch.pos_y      <= b.pos[1];
    in_ch.pos_z      <= b.pos[2];
    in_ch.step_time  <= b.step_time;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    model = predict_sleep(b);
    due_results.insert(due_results.size(), typed ? want : model);
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Writes one register, then reads it back.
  task automatic cfg_write(input rbst_pkg::reg_index_t idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] readback;
    mask = (idx == rbst_pkg::REG_STILL_RADIUS) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((readback & mask) !== (value & mask)) begin
      $error("register %s: expected %0h, got %0h", idx.name(), value & mask, readback & mask);
      cfg_fault_count++;
    end
    case (idx)
      rbst_pkg::REG_LINEAR_REST_SQ:  lin_rest_sq = value;
      rbst_pkg::REG_ANGULAR_REST_SQ: ang_rest_sq = value;
      rbst_pkg::REG_REST_TIME:       rest_dur = value;
      rbst_pkg::REG_STILL_RADIUS:    still_rad = value[rbst_pkg::RADIUS_W-1:0];
      rbst_pkg::REG_STILL_TIME:      still_dur = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] lin, input logic [31:0] ang,
                                input logic [31:0] rest, input logic [31:0] radius,
                                input logic [31:0] still);
    cfg_write(rbst_pkg::REG_LINEAR_REST_SQ, lin);
    cfg_write(rbst_pkg::REG_ANGULAR_REST_SQ, ang);
    cfg_write(rbst_pkg::REG_REST_TIME, rest);
    cfg_write(rbst_pkg::REG_STILL_RADIUS, radius);
    cfg_write(rbst_pkg::REG_STILL_TIME, still);
    settings_used++;
  endtask

  // Result side: check against the oldest expectation, then maybe stall.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result for body %0d arrived with nothing expected", out_ch.body_index_out);
        fault_count++;
      end else begin
        oldest_due = due_results.pop_front();
        if (out_ch.body_index_out !== oldest_due.body_index) begin
          $error("body_index_out: expected %0d, got %0d",
                 oldest_due.body_index, out_ch.body_index_out);
          fault_count++;
        end
        if (out_ch.asleep !== oldest_due.asleep) begin
          $error("asleep (body %0d): expected %0b, got %0b",
                 oldest_due.body_index, oldest_due.asleep, out_ch.asleep);
          fault_count++;
        end
        if (out_ch.zero_velocity !== oldest_due.zero_velocity) begin
          $error("zero_velocity (body %0d): expected %0b, got %0b",
                 oldest_due.body_index, oldest_due.zero_velocity, out_ch.zero_velocity);
          fault_count++;
        end
        results_checked++;
        if (oldest_due.zero_velocity) sleeps_seen++;
      end
      sink_wait = no_idle ? 0 : $urandom_range(0, 10);
    end
    if (sink_wait > 0) begin
      out_ch.ready <= 1'b0;
      sink_wait--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("Watchdog: no item moved for %0d cycles, %0d results outstanding.",
             QUIET_LIMIT, due_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rbst_pkg::res_t none;
    int             directed;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.body_index <= '0;
    in_ch.is_static  <= 1'b0;
    in_ch.lin_vel_x  <= '0;
    in_ch.lin_vel_y  <= '0;
    in_ch.lin_vel_z  <= '0;
    in_ch.ang_vel_x  <= '0;
    in_ch.ang_vel_y  <= '0;
    in_ch.ang_vel_z  <= '0;
    in_ch.pos_x      <= '0;
    in_ch.pos_y      <= '0;
    in_ch.pos_z      <= '0;
    in_ch.step_time  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    none           = '0;
    no_idle        = 1'b0;
    cfg_fault_count = 0;
    items_sent     = 0;
    settings_used  = 1;
    lin_rest_sq    = rbst_pkg::LINEAR_REST_SQ_RST;
    ang_rest_sq    = rbst_pkg::ANGULAR_REST_SQ_RST;
    rest_dur       = rbst_pkg::REST_TIME_RST;
    still_rad      = rbst_pkg::STILL_RADIUS_RST;
    still_dur      = rbst_pkg::STILL_TIME_RST;
    for (int i = 0; i < rbst_pkg::BODY_COUNT; i++) begin
      body_asleep[i]    = 1'b0;
      slow_time_acc[i]  = '0;
      still_time_acc[i] = '0;
      anchor_pos[i]     = '0;
    end

    // Directed items under the reset register values.
    add_probe(make_body(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_probe(make_body(1, 1, 32767, 32767, 0, 0, 0, 65535), 1, 0, 0);
    add_probe(make_body(2, 0, -32768, -32768, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 65535), 1, 0, 0);
    // Opposite position extreme: the differences saturate before squaring.
    add_probe(make_body(2, 0, 32767, 32767, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 65535), 1, 0, 0);
    add_probe(make_body(3, 0, 0, 0, 0, 0, 0, 65535), 1, 1, 1);
    add_probe(make_body(3, 0, 0, 0, 0, 0, 0, 65535), 1, 1, 0);
    add_probe(make_body(3, 1, 0, 0, 0, 0, 0, 65535), 1, 1, 0);
    add_probe(make_body(3, 0, 256, 0, 0, 0, 0, 65535));
    // Build up the still timer, sleep on slow motion, then wake and re-sleep
    // on position in one step.
    add_probe(make_body(4, 0, 256, 0, 0, 0, 0, 65535));
    add_probe(make_body(4, 0, 256, 0, 0, 0, 0, 65535));
    add_probe(make_body(4, 0, 0, 0, 0, 0, 0, 65535));
    add_probe(make_body(4, 0, 256, 0, 0, 0, 0, 65535));
    // Speed thresholds just below and just above.
    add_probe(make_body(5, 0, 14, 14, 0, 0, 0, 1));
    add_probe(make_body(5, 0, 15, 0, 0, 0, 0, 1));
    add_probe(make_body(5, 0, -14, -14, 0, 0, 0, 1));
    // Distance zero, then exactly at the radius, then inside it.
    add_probe(make_body(6, 0, 256, 0, 0, 0, 0, 100));
    add_probe(make_body(6, 0, 256, 0, 4, 0, 0, 100));
    add_probe(make_body(6, 0, 256, 0, 6, 2, 2, 100));
    add_probe(make_body(1023, 0, 0, 0, -1, -1, -1, 65535));
    add_probe(make_body(1023, 1, -1, -1, -1, -1, -1, 0));
    add_probe(make_body(1023, 0, -1, -1, -1, -1, -1, 65535));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    directed = probes.size();
    foreach (probes[k]) send_body(probes[k].body, probes[k].typed, probes[k].want);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      apply_settings(PHASE_CFG[p][0], PHASE_CFG[p][1], PHASE_CFG[p][2],
                     PHASE_CFG[p][3], PHASE_CFG[p][4]);
      foreach (bodies_in_play[k])
        bodies_in_play[k] = $urandom_range(0, rbst_pkg::BODY_COUNT - 1);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        if (p == 4 && n == PHASE_ITEMS[p] / 2) drain_results();
        send_body(random_body(), 1'b0, none);
      end
    end
    no_idle = 1'b0;

    drain_results();
    $display("Sent %0d body items (%0d directed) under %0d register settings.",
             items_sent, directed, settings_used);
    $display("Compared %0d results, %0d of them sleep transitions.",
             results_checked, sleeps_seen);
    if (fault_count == 0 && cfg_fault_count == 0 && due_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
